// ===== rtl/lafade_pkg.sv =====
package lafade_pkg;

   localparam int SAMPLE_W = 16;
   localparam int REG_W    = 32;
   localparam int PROD_W   = REG_W + SAMPLE_W;
   localparam int STEP_W   = $clog2(SAMPLE_W);
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] REG_FADE_MODE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FADE_LENGTH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TOTAL_SAMPLES = 2'd2;

   typedef struct packed {
      logic busy;
      logic done;
   } md_stat_type;

endpackage

// ===== rtl/linear_audio_fade_top.sv =====
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_pcm_in, req_clip_start
// rsp       out        rsp_valid/rsp_stall  rsp_pcm_out
// csr       in         csr_valid/csr_ready  csr_index, csr_wdata
//
// A sample on the ramp goes from one request to the next through capture, a decision
// state, 16 multiply and 16 divide steps of the bit-serial unit, taking the quotient
// and a hold state. A sample off the ramp passes only capture, decision and hold.
// One request is in work at a time. Reset is synchronous and clears the registers,
// the sample index and the control.
// A finished result waits in the output register while the next request is taken.
module linear_audio_fade_top #(
   parameter int INDEX_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [lafade_pkg::SAMPLE_W-1:0] req_pcm_in,
   input  logic                                  req_clip_start,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [lafade_pkg::SAMPLE_W-1:0] rsp_pcm_out,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lafade_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lafade_pkg::REG_W-1:0]           csr_wdata
);
   import lafade_pkg::*;

   localparam int EXT_W = ((INDEX_BITS > REG_W) ? INDEX_BITS : REG_W) + 1;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DECIDE = 2'd1;
   localparam logic [1:0] ST_CALC   = 2'd2;
   localparam logic [1:0] ST_HOLD   = 2'd3;

   localparam logic [INDEX_BITS-1:0] IDX_MAX = '1;

   logic [1:0]            state_ff, state_in;
   logic                  mode_ff, mode_in;
   logic [REG_W-1:0]      len_ff, len_in;
   logic [REG_W-1:0]      total_ff, total_in;
   logic [INDEX_BITS-1:0] sample_index_ff, sample_index_in;
   logic [INDEX_BITS-1:0] idx_ff, idx_in;
   logic [SAMPLE_W-1:0]   sample_ff, sample_in;
   logic [SAMPLE_W-1:0]   result_ff, result_in;
   logic [SAMPLE_W-1:0]   rsp_pcm_out_ff, rsp_pcm_out_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [INDEX_BITS-1:0] idx_sel;
   logic [EXT_W-1:0]      idx_ext, len_ext, tot_ext, ramp_sum, tail_diff;
   logic                  fadein_ramp, fadeout_ramp, past_end;
   logic [SAMPLE_W-1:0]   mag;
   logic [SAMPLE_W-1:0]   quot_signed;

   logic                  md_start;
   logic [REG_W-1:0]      md_num;
   logic [SAMPLE_W-1:0]   md_quot;
   md_stat_type           md_stat;

   assign idx_sel = req_clip_start ? '0 : sample_index_ff;

   assign idx_ext      = EXT_W'(idx_ff);
   assign len_ext      = EXT_W'(len_ff);
   assign tot_ext      = EXT_W'(total_ff);
   assign ramp_sum     = idx_ext + len_ext;
   assign tail_diff    = tot_ext - idx_ext;
   assign fadein_ramp  = (idx_ext < len_ext);
   assign fadeout_ramp = (ramp_sum > tot_ext);
   assign past_end     = (idx_ext >= tot_ext);

   // Inside the ramp the numerator is below the fade length, so 32 bits hold it.
   assign md_num      = mode_ff ? tail_diff[REG_W-1:0] : idx_ext[REG_W-1:0];
   assign mag         = sample_ff[SAMPLE_W-1] ? (~sample_ff + SAMPLE_W'(1)) : sample_ff;
   assign quot_signed = sample_ff[SAMPLE_W-1] ? (~md_quot + SAMPLE_W'(1)) : md_quot;

   lafade_muldiv u_muldiv (
      .clock    (clock),
      .reset    (reset),
      .md_start (md_start),
      .md_num   (md_num),
      .md_den   (len_ff),
      .md_mag   (mag),
      .md_quot  (md_quot),
      .md_stat  (md_stat)
   );

   always_comb begin
      mode_in  = mode_ff;
      len_in   = len_ff;
      total_in = total_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_FADE_MODE:     mode_in  = csr_wdata[0];
            REG_FADE_LENGTH:   len_in   = csr_wdata;
            REG_TOTAL_SAMPLES: total_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in        = state_ff;
      sample_index_in = sample_index_ff;
      idx_in          = idx_ff;
      sample_in       = sample_ff;
      result_in       = result_ff;
      rsp_pcm_out_in  = rsp_pcm_out_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      md_start        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               idx_in          = idx_sel;
               sample_in       = req_pcm_in;
               sample_index_in = (idx_sel == IDX_MAX) ? IDX_MAX : idx_sel + INDEX_BITS'(1);
               state_in        = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            result_in = sample_ff;
            state_in  = ST_HOLD;
            if (len_ff != '0) begin
               if (!mode_ff) begin
                  if (fadein_ramp) begin
                     md_start = 1'b1;
                     state_in = ST_CALC;
                  end
               end else if (fadeout_ramp) begin
                  if (past_end) begin
                     result_in = '0;
                  end else begin
                     md_start = 1'b1;
                     state_in = ST_CALC;
                  end
               end
            end
         end
         ST_CALC: begin
            if (md_stat.done) begin
               result_in = quot_signed;
               state_in  = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_pcm_out_in = result_ff;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         mode_ff         <= 1'b0;
         len_ff          <= '0;
         total_ff        <= '0;
         sample_index_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         mode_ff         <= mode_in;
         len_ff          <= len_in;
         total_ff        <= total_in;
         sample_index_ff <= sample_index_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      idx_ff         <= idx_in;
      sample_ff      <= sample_in;
      result_ff      <= result_in;
      rsp_pcm_out_ff <= rsp_pcm_out_in;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pcm_out = rsp_pcm_out_ff;
   assign csr_ready   = 1'b1;

`ifndef SYNTHESIS
   a_accept_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted but the next one was not held off");

   a_calc_has_unit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CALC) |-> (md_stat.busy || md_stat.done))
      else $error("waiting on the multiply-divide unit while it is idle");

   a_hold_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD && (!rsp_valid || !rsp_stall)) |=>
         (rsp_valid && state_ff == ST_IDLE))
      else $error("finished result was not moved to the output register");
`endif

endmodule

// ===== rtl/lafade_muldiv.sv =====
module lafade_muldiv (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               md_start,
   input  logic [lafade_pkg::REG_W-1:0]       md_num,
   input  logic [lafade_pkg::REG_W-1:0]       md_den,
   input  logic [lafade_pkg::SAMPLE_W-1:0]    md_mag,
   output logic [lafade_pkg::SAMPLE_W-1:0]    md_quot,
   output lafade_pkg::md_stat_type            md_stat
);
   import lafade_pkg::*;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_MUL  = 2'd1;
   localparam logic [1:0] PH_DIV  = 2'd2;

   logic [1:0]          phase_ff, phase_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [PROD_W-1:0]   acc_ff, acc_in;
   logic [SAMPLE_W-1:0] mag_ff, mag_in;
   logic [REG_W-1:0]    num_ff, num_in;
   logic [REG_W-1:0]    den_ff, den_in;
   logic                done_ff, done_in;

   logic [PROD_W-1:0]   addend;
   logic [PROD_W-1:0]   mul_next;
   logic [REG_W:0]      trial;
   logic [REG_W+1:0]    diff;
   logic                ge;
   logic [REG_W-1:0]    rem_new;
   logic [PROD_W-1:0]   div_next;
   logic                last;

   // The multiply runs MSB first over the magnitude bits. The divide then
   // keeps the remainder in the upper word and shifts quotient bits into
   // the lower word; the product is below den * 2^16, so the upper word
   // starts out smaller than the divisor.
   assign addend   = mag_ff[SAMPLE_W-1] ? PROD_W'(num_ff) : '0;
   assign mul_next = {acc_ff[PROD_W-2:0], 1'b0} + addend;
   assign trial    = acc_ff[PROD_W-1:SAMPLE_W-1];
   assign diff     = {1'b0, trial} - {2'b00, den_ff};
   assign ge       = ~diff[REG_W+1];
   assign rem_new  = ge ? diff[REG_W-1:0] : trial[REG_W-1:0];
   assign div_next = {rem_new, acc_ff[SAMPLE_W-2:0], ge};
   assign last     = (step_ff == STEP_W'(SAMPLE_W - 1));

   always_comb begin
      phase_in = phase_ff;
      step_in  = step_ff + STEP_W'(1);
      acc_in   = acc_ff;
      mag_in   = mag_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      done_in  = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (md_start) begin
               num_in   = md_num;
               den_in   = md_den;
               mag_in   = md_mag;
               acc_in   = '0;
               step_in  = '0;
               phase_in = PH_MUL;
            end
         end
         PH_MUL: begin
            acc_in = mul_next;
            mag_in = {mag_ff[SAMPLE_W-2:0], 1'b0};
            if (last) begin
               phase_in = PH_DIV;
            end
         end
         PH_DIV: begin
            acc_in = div_next;
            if (last) begin
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      step_ff <= step_in;
      acc_ff  <= acc_in;
      mag_ff  <= mag_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
   end

   assign md_quot      = acc_ff[SAMPLE_W-1:0];
   assign md_stat.busy = (phase_ff != PH_IDLE);
   assign md_stat.done = done_ff;

endmodule

// ===== bench/linear_audio_fade_checker.sv =====
`timescale 1ns / 100ps
module linear_audio_fade_checker #(
   parameter int INDEX_BITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_stall,
   input  logic signed [lafade_pkg::SAMPLE_W-1:0] req_pcm_in,
   input  logic                                   req_clip_start,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic signed [lafade_pkg::SAMPLE_W-1:0] rsp_pcm_out,
   input  logic                                   csr_valid,
   input  logic                                   csr_ready,
   input  logic [lafade_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lafade_pkg::REG_W-1:0]           csr_wdata,
   output int                                     fail_count,
   output int                                     outstanding
);
   import lafade_pkg::*;

   localparam logic [63:0] INDEX_MAX = (64'd1 << INDEX_BITS) - 64'd1;

   logic                       fade_out;
   logic [63:0]                fade_len;
   logic [63:0]                clip_total;
   logic [63:0]                next_index;
   logic signed [SAMPLE_W-1:0] expected_pcm[$];

   // Exact trunc(num * s / fade_len); the caller guarantees num < fade_len.
   function automatic logic signed [SAMPLE_W-1:0] ramp_scaled(
      input logic signed [SAMPLE_W-1:0] s, input logic [63:0] num);
      logic signed [31:0] wide;
      logic [63:0]        mag;
      logic [63:0]        quot;
      wide = s;
      mag  = (wide < 0) ? 64'(-wide) : 64'(wide);
      quot = (num * mag) / fade_len;
      return (wide < 0) ? -quot[SAMPLE_W-1:0] : quot[SAMPLE_W-1:0];
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] faded_sample(
      input logic signed [SAMPLE_W-1:0] s, input logic [63:0] idx);
      logic signed [SAMPLE_W-1:0] faded;
      faded = s;
      if (fade_len != 0) begin
         if (!fade_out) begin
            if (idx < fade_len) faded = ramp_scaled(s, idx);
         end else if (idx + fade_len > clip_total) begin
            // Past the end of the clip the gain is clamped to zero.
            if (idx >= clip_total) faded = '0;
            else faded = ramp_scaled(s, clip_total - idx);
         end
      end
      return faded;
   endfunction

   always @(posedge clock) begin
      logic [63:0]                idx;
      logic signed [SAMPLE_W-1:0] want;
      if (reset) begin
         fade_out   = 1'b0;
         fade_len   = '0;
         clip_total = '0;
         next_index = '0;
         expected_pcm.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_FADE_MODE:     fade_out = csr_wdata[0];
               REG_FADE_LENGTH:   fade_len = 64'(csr_wdata);
               REG_TOTAL_SAMPLES: clip_total = 64'(csr_wdata);
               default: ;
            endcase
         end
         // Results are matched before the new request is queued, so a result
         // can never be paired with a request taken at the same edge.
         if (rsp_valid && !rsp_stall) begin
            if (expected_pcm.size() == 0) begin
               $display("%0t: pcm_out with no request waiting, expected none, actual %0d",
                        $time, rsp_pcm_out);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_pcm.pop_front();
               if (rsp_pcm_out !== want) begin
                  $display("%0t: pcm_out mismatch, expected %0d, actual %0d",
                           $time, want, rsp_pcm_out);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            idx = req_clip_start ? 64'd0 : next_index;
            expected_pcm.push_back(faded_sample(req_pcm_in, idx));
            next_index = (idx >= INDEX_MAX) ? INDEX_MAX : idx + 64'd1;
         end
      end
      outstanding <= expected_pcm.size();
   end

endmodule

// ===== bench/linear_audio_fade_top_tb.sv =====
`timescale 1ns / 100ps
module linear_audio_fade_top_tb;
   import lafade_pkg::*;

   localparam int   INDEX_BITS     = 32;
   localparam int   ITEM_TARGET    = 1050;
   localparam int   IDLE_CYCLES    = 40;
   localparam int   WATCHDOG_LIMIT = 2000;
   localparam logic FADE_IN        = 1'b0;
   localparam logic FADE_OUT       = 1'b1;

   logic                       clock          = 1'b0;
   logic                       reset          = 1'b1;
   logic                       req_valid      = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_pcm_in     = '0;
   logic                       req_clip_start = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall      = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_pcm_out;
   logic                       csr_valid      = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index      = '0;
   logic [REG_W-1:0]           csr_wdata      = '0;

   int fail_count;
   int outstanding;
   int sent         = 0;
   int rsp_hold     = 0;
   int quiet_cycles = 0;
   bit req_quiet    = 1'b0;
   bit rsp_quiet    = 1'b0;

   linear_audio_fade_top #(.INDEX_BITS(INDEX_BITS)) dut (.*);

   linear_audio_fade_checker #(.INDEX_BITS(INDEX_BITS)) fade_checker (.*);

   always #5 clock = ~clock;

   // The stall drawn after each accepted result is spent only while a result
   // is offered, so every result is held off for the whole drawn stall.
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         rsp_hold = rsp_quiet ? 0 : $urandom_range(0, 19);
      end else if (rsp_valid && rsp_hold > 0) begin
         rsp_hold = rsp_hold - 1;
      end
      rsp_stall <= (rsp_hold > 0);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Valid stays high across back-to-back requests; it is lowered only
   // when a gap is drawn or when the bench settles.
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] pcm, input logic start);
      int gap;
      gap = req_quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_pcm_in     <= pcm;
      req_clip_start <= start;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] which, input logic [REG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [REG_W-1:0] mode_word, input logic [REG_W-1:0] len_word,
                            input logic [REG_W-1:0] total_word);
      settle();
      write_reg(REG_FADE_MODE, mode_word);
      write_reg(REG_FADE_LENGTH, len_word);
      write_reg(REG_TOTAL_SAMPLES, total_word);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [REG_W-1:0]           len_word;
      logic [REG_W-1:0]           total_word;
      logic signed [SAMPLE_W-1:0] pcm;
      logic                       start;
      bit                         skip_start;
      int                         phase_left;
      int                         clip_len;
      int                         k;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Registers still at reset: zero fade length passes every sample.
      send_sample(16'sh7FFF, 1'b1);
      send_sample(-16'sh8000, 1'b0);
      send_sample('0, 1'b0);
      send_sample(-16'sd1, 1'b0);

      configure({31'd0, FADE_IN}, 32'd4, 32'd0);
      send_sample(-16'sh8000, 1'b1);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(-16'sh8000, 1'b0);
      send_sample(-16'sd3, 1'b0);
      send_sample(16'sd12345, 1'b0);
      send_sample(16'sh7FFF, 1'b1);

      // Ramp near the clip end, then indexes at and past the end.
      configure({31'd0, FADE_OUT}, 32'd3, 32'd5);
      for (k = 0; k < 7; k++) send_sample(k[0] ? -16'sh8000 : 16'sh7FFF, k == 0);

      // Ramp longer than the clip itself.
      configure({31'd0, FADE_OUT}, 32'd8, 32'd3);
      for (k = 0; k < 5; k++) send_sample(k[0] ? 16'sh7FFF : -16'sh8000, k == 0);

      configure({31'd0, FADE_IN}, '1, 32'd0);
      send_sample(16'sh7FFF, 1'b1);
      send_sample(-16'sh8000, 1'b0);

      configure({31'd0, FADE_OUT}, '1, '1);
      send_sample(-16'sh8000, 1'b1);
      send_sample(16'sh7FFF, 1'b0);

      while (sent < ITEM_TARGET) begin
         case ($urandom_range(0, 7))
            0: len_word = '0;
            1: len_word = '1;
            2: len_word = $urandom;
            default: len_word = $urandom_range(1, 64);
         endcase
         case ($urandom_range(0, 7))
            0: total_word = '0;
            1: total_word = '1;
            2: total_word = $urandom;
            default: total_word = $urandom_range(0, 100);
         endcase
         configure($urandom, len_word, total_word);
         req_quiet  = ($urandom_range(0, 3) == 0);
         rsp_quiet  = ($urandom_range(0, 3) == 0);
         phase_left = $urandom_range(30, 120);
         // Now and then the index runs on from the previous phase.
         skip_start = ($urandom_range(0, 3) == 0);
         while (phase_left > 0) begin
            clip_len = $urandom_range(1, 130);
            for (k = 0; k < clip_len && phase_left > 0; k++) begin
               start = (k == 0 && !skip_start) || ($urandom_range(0, 31) == 0);
               case ($urandom_range(0, 9))
                  0: pcm = 16'sh7FFF;
                  1: pcm = -16'sh8000;
                  2: pcm = '0;
                  3: pcm = -16'sd1;
                  default: pcm = SAMPLE_W'($urandom);
               endcase
               send_sample(pcm, start);
               phase_left--;
            end
            skip_start = 1'b0;
         end
      end

      settle();
      if (fail_count == 0 && outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
